FILE: src/qpud_pkg.sv
package qpud_pkg;

    // Longest key name the matcher compares, in bytes.
    localparam int unsigned KEY_BYTES_MAX = 8;
    localparam int unsigned KEY_W         = 8 * KEY_BYTES_MAX;
    localparam int unsigned KEY_LEN_W     = 4;
    localparam int unsigned KEY_IDX_W     = $clog2(KEY_BYTES_MAX);

    // Configuration register indexes.
    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    // Characters with a special meaning in a query string.
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Parse phase of the current query string.
    typedef enum logic [3:0] {
        PH_SCAN     = 4'b0001,
        PH_VALUE    = 4'b0010,
        PH_DONE     = 4'b0100,
        PH_DONE_BAD = 4'b1000
    } t_phase;

    // Hex digit value; bit 4 is set when the byte is not an uppercase hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = b - CH_ZERO;
            return {1'b0, v[3:0]};
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            v = b - CH_UPPER_A + 8'd10;
            return {1'b0, v[3:0]};
        end
        return 5'b10000;
    endfunction

endpackage

FILE: src/query_param_url_decoder_unit.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// config   | i_cfg_we               | i_cfg_index, i_cfg_data (64 bits)
// input    | i_in_valid / o_in_ready| i_in_byte, i_in_last
// output   | o_out_valid/i_out_ready| o_out_byte, o_byte_valid, o_frame_end,
//          |                        | o_found, o_bad_escape
//
// One byte per cycle is sustained unless a byte that makes a result meets a full
// result register that is not taken. A transaction is held in the input register,
// then the parse step updates the state and loads the result register.
// Reset (synchronous, active low) clears the parse state and both key registers.
// A full result register that is not taken stalls only bytes that make a result;
// bytes that make none pass through the parse step regardless.
module query_param_url_decoder_unit
    import qpud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_frame_end,
    output logic        o_found,
    output logic        o_bad_escape
);

    logic [KEY_W-1:0]     r_key_bytes;
    logic [KEY_LEN_W-1:0] r_key_length;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_phase         r_phase,     n_phase;
    logic [KEY_LEN_W-1:0] r_match_pos, n_match_pos;
    logic           r_mismatch,  n_mismatch;
    logic [1:0]     r_hex_left,  n_hex_left;
    logic [7:0]     r_hex_acc,   n_hex_acc;
    logic           r_key_found, n_key_found;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_byte_valid;
    logic       r_frame_end;
    logic       r_found;
    logic       r_bad_escape;

    logic [KEY_LEN_W-1:0] w_eff_len;
    logic [7:0]           w_key_char;
    logic [4:0]           w_digit;
    logic                 w_emit;
    logic [7:0]           w_emit_byte;
    logic                 w_bad;
    logic                 w_produce;
    logic                 w_out_free;
    logic                 w_advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= '0;
            r_key_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:  r_key_bytes  <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[KEY_LEN_W-1:0];
                default:        r_key_length <= r_key_length;
            endcase
        end
    end

    // Handshake: the parse step moves a byte on unless it makes a result that cannot land.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_produce || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // Key length is clamped to the longest supported key.
    assign w_eff_len  = (r_key_length > KEY_LEN_W'(KEY_BYTES_MAX)) ?
                        KEY_LEN_W'(KEY_BYTES_MAX) : r_key_length;
    assign w_key_char = r_key_bytes[{r_match_pos[KEY_IDX_W-1:0], 3'b000} +: 8];
    assign w_digit    = hex_value(r_in_byte);

    // Parse step for the byte in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_match_pos = r_match_pos;
        n_mismatch  = r_mismatch;
        n_hex_left  = r_hex_left;
        n_hex_acc   = r_hex_acc;
        n_key_found = r_key_found;
        w_emit      = 1'b0;
        w_emit_byte = 8'd0;
        w_bad       = 1'b0;

        unique case (r_phase)
            PH_SCAN: begin
                if (r_in_byte == CH_EQUAL) begin
                    if (!r_mismatch && r_match_pos == w_eff_len) begin
                        n_key_found = 1'b1;
                        n_phase     = PH_VALUE;
                        n_hex_left  = 2'd0;
                        n_hex_acc   = 8'd0;
                    end
                    n_match_pos = '0;
                    n_mismatch  = 1'b0;
                end else if (r_in_byte == CH_AMP) begin
                    n_match_pos = '0;
                    n_mismatch  = 1'b0;
                end else if (!r_mismatch) begin
                    if (r_match_pos < w_eff_len && w_key_char == r_in_byte) begin
                        n_match_pos = r_match_pos + KEY_LEN_W'(1);
                    end else begin
                        n_mismatch = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                if (r_in_byte == CH_AMP) begin
                    n_phase    = (r_hex_left != 2'd0) ? PH_DONE_BAD : PH_DONE;
                    n_hex_left = 2'd0;
                end else if (r_hex_left != 2'd0) begin
                    // Non-digits inside an escape are skipped and keep it open.
                    if (!w_digit[4]) begin
                        n_hex_acc  = {r_hex_acc[3:0], w_digit[3:0]};
                        n_hex_left = r_hex_left - 2'd1;
                        if (r_hex_left == 2'd1) begin
                            w_emit      = 1'b1;
                            w_emit_byte = {r_hex_acc[3:0], w_digit[3:0]};
                        end
                    end
                end else if (r_in_byte == CH_PERCENT) begin
                    n_hex_left = 2'd2;
                    n_hex_acc  = 8'd0;
                end else begin
                    w_emit      = 1'b1;
                    w_emit_byte = (r_in_byte == CH_PLUS) ? CH_SPACE : r_in_byte;
                end
            end
            PH_DONE, PH_DONE_BAD: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_SCAN;
            end
        endcase

        // The closing byte reports the outcome and returns the state to its reset values.
        if (r_in_last) begin
            w_bad = (n_phase == PH_DONE_BAD) ||
                    (n_phase == PH_VALUE && n_hex_left != 2'd0);
        end
    end

    assign w_produce = w_emit || r_in_last;

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SCAN;
            r_match_pos <= '0;
            r_mismatch  <= 1'b0;
            r_hex_left  <= 2'd0;
            r_hex_acc   <= 8'd0;
            r_key_found <= 1'b0;
        end else if (w_advance) begin
            if (r_in_last) begin
                r_phase     <= PH_SCAN;
                r_match_pos <= '0;
                r_mismatch  <= 1'b0;
                r_hex_left  <= 2'd0;
                r_hex_acc   <= 8'd0;
                r_key_found <= 1'b0;
            end else begin
                r_phase     <= n_phase;
                r_match_pos <= n_match_pos;
                r_mismatch  <= n_mismatch;
                r_hex_left  <= n_hex_left;
                r_hex_acc   <= n_hex_acc;
                r_key_found <= n_key_found;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_produce) begin
            r_out_byte   <= w_emit_byte;
            r_byte_valid <= w_emit;
            r_frame_end  <= r_in_last;
            r_found      <= r_in_last && n_key_found;
            r_bad_escape <= w_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_frame_end  = r_frame_end;
    assign o_found      = r_found;
    assign o_bad_escape = r_bad_escape;

    // A result without a character is only the closing result of a string.
    a_empty_is_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> o_frame_end)
        else $error("result without character and without frame end");

    // Outcome flags appear only on the closing result.
    a_flags_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_end) |-> (!o_found && !o_bad_escape))
        else $error("found or bad_escape outside frame end");

    // After the last byte of a string the parser starts over.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> (r_phase == PH_SCAN && !r_key_found &&
                                      r_hex_left == 2'd0))
        else $error("parse state not cleared after frame end");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(w_advance && w_produce))
        else $error("stalled result overwritten");

endmodule

FILE: tb/qpud_tb_pkg.sv
package qpud_tb_pkg;

    import qpud_pkg::*;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       found;
        logic       bad_escape;
    } t_decoded;

    // Tracks the parse of each query string and holds the decoded results still owed.
    class decode_scoreboard;
        logic [KEY_W-1:0]     key_bytes;
        logic [KEY_LEN_W-1:0] key_length;
        t_phase               phase;
        int unsigned          match_pos;
        bit                   seg_mismatch;
        int unsigned          digits_left;
        logic [7:0]           hex_acc;
        bit                   key_hit;
        t_decoded             decoded_q[$];
        int unsigned          error_count;

        function new();
            key_bytes   = '0;
            key_length  = '0;
            error_count = 0;
            clear_parse();
        endfunction

        // Parse state goes back to its reset value; the key registers stay.
        function void clear_parse();
            phase        = PH_SCAN;
            match_pos    = 0;
            seg_mismatch = 1'b0;
            digits_left  = 0;
            hex_acc      = '0;
            key_hit      = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [63:0] data);
            if (idx == CFG_KEY_BYTES) begin
                key_bytes = data;
            end else begin
                key_length = data[KEY_LEN_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction

        // Advance the parse by one accepted byte and queue the result it causes.
        function void note_byte(logic [7:0] b, logic last);
            int unsigned klen;
            logic [3:0]  nib;
            bit          is_hex;
            bit          emit;
            t_decoded    res;
            klen = (key_length > KEY_BYTES_MAX) ? KEY_BYTES_MAX : key_length;
            emit = 1'b0;
            res  = '0;
            nib  = '0;
            case (phase)
                PH_SCAN: begin
                    if (b == CH_EQUAL) begin
                        if (!seg_mismatch && match_pos == klen) begin
                            key_hit     = 1'b1;
                            phase       = PH_VALUE;
                            digits_left = 0;
                            hex_acc     = '0;
                        end
                        match_pos    = 0;
                        seg_mismatch = 1'b0;
                    end else if (b == CH_AMP) begin
                        match_pos    = 0;
                        seg_mismatch = 1'b0;
                    end else if (!seg_mismatch) begin
                        if (match_pos < klen && key_bytes[8*match_pos +: 8] == b) begin
                            match_pos++;
                        end else begin
                            seg_mismatch = 1'b1;
                        end
                    end
                end
                PH_VALUE: begin
                    if (b == CH_AMP) begin
                        phase       = (digits_left != 0) ? PH_DONE_BAD : PH_DONE;
                        digits_left = 0;
                    end else if (digits_left != 0) begin
                        // Digits '0'..'9' carry their value in the low nibble, 'A'..'F' are
                        // offset by nine. Anything else inside an escape is dropped.
                        is_hex = 1'b1;
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            nib = b[3:0];
                        end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
                            nib = b[3:0] + 4'd9;
                        end else begin
                            is_hex = 1'b0;
                        end
                        if (is_hex) begin
                            hex_acc = {hex_acc[3:0], nib};
                            digits_left--;
                            if (digits_left == 0) begin
                                emit         = 1'b1;
                                res.out_byte = hex_acc;
                            end
                        end
                    end else if (b == CH_PERCENT) begin
                        digits_left = 2;
                        hex_acc     = '0;
                    end else begin
                        emit         = 1'b1;
                        res.out_byte = (b == CH_PLUS) ? CH_SPACE : b;
                    end
                end
                default: begin
                end
            endcase

            if (emit || last) begin
                res.byte_valid = emit;
                res.frame_end  = last;
                if (last) begin
                    res.found      = key_hit;
                    res.bad_escape = (phase == PH_DONE_BAD) ||
                                     (phase == PH_VALUE && digits_left != 0);
                    clear_parse();
                end
                decoded_q.push_back(res);
            end
        endfunction

        // Compare one output transaction with the oldest owed result.
        function void check_decoded(t_decoded got);
            t_decoded want;
            if (decoded_q.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: byte=%02h valid=%0d end=%0d found=%0d bad=%0d",
                             got.out_byte, got.byte_valid, got.frame_end, got.found,
                             got.bad_escape);
                end
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.frame_end !== want.frame_end || got.found !== want.found ||
                got.bad_escape !== want.bad_escape) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("result mismatch: expected byte=%02h valid=%0d end=%0d found=%0d bad=%0d",
                             want.out_byte, want.byte_valid, want.frame_end, want.found,
                             want.bad_escape);
                    $display("                 actual   byte=%02h valid=%0d end=%0d found=%0d bad=%0d",
                             got.out_byte, got.byte_valid, got.frame_end, got.found,
                             got.bad_escape);
                end
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;

    import qpud_pkg::*;
    import qpud_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES  = 1550;
    localparam int unsigned NUM_SETTINGS  = 7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_frame_end;
    logic        o_found;
    logic        o_bad_escape;

    decode_scoreboard sb;
    bit               gaps_on = 1'b1;
    bit               hold_request = 1'b0;
    logic [7:0]       query_q[$];
    logic [63:0]      cur_key;
    int unsigned      cur_len;
    int unsigned      bytes_sent = 0;
    int unsigned      cycle_count = 0;
    int unsigned      key_lens[NUM_SETTINGS] = '{3, 8, 15, 0, 1, 9, 5};

    query_param_url_decoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_frame_end  (o_frame_end),
        .o_found      (o_found),
        .o_bad_escape (o_bad_escape)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Every accepted output transaction is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_decoded({o_out_byte, o_byte_valid, o_frame_end, o_found, o_bad_escape});
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Offer one byte and wait for its transaction; random idle cycles go first.
    task automatic send_byte(logic [7:0] b, logic last);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, last);
    endtask

    task automatic send_query();
        for (int i = 0; i < query_q.size(); i++) begin
            send_byte(query_q[i], i == query_q.size() - 1);
        end
        bytes_sent += query_q.size();
    endtask

    // Stop offering, wait for every owed result, then let in-flight bytes settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Program both key registers; the length word carries random upper bits.
    task automatic set_key(logic [3:0] klen, logic [63:0] kbytes);
        logic [63:0] len_word;
        len_word      = {$urandom(), $urandom()};
        len_word[3:0] = klen;
        write_cfg(CFG_KEY_BYTES, kbytes);
        write_cfg(CFG_KEY_LENGTH, len_word);
        i_cfg_we <= 1'b0;
        cur_key = kbytes;
        cur_len = (klen > KEY_BYTES_MAX) ? KEY_BYTES_MAX : klen;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            query_q.push_back(s[i]);
        end
    endfunction

    function automatic void append_key(int unsigned n);
        for (int i = 0; i < n; i++) begin
            query_q.push_back(cur_key[8*i +: 8]);
        end
    endfunction

    // Names use a tiny alphabet so that partial key matches are common.
    function automatic logic [7:0] name_char();
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] hex_char(int unsigned d);
        return (d < 10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d - 10);
    endfunction

    // One value character: plain, plus, escapes good, broken and incomplete, raw bytes.
    function automatic void append_value_char();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick <= 8) begin
            query_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
        end else if (pick <= 10) begin
            query_q.push_back(CH_PLUS);
        end else if (pick <= 13) begin
            query_q.push_back(CH_PERCENT);
            query_q.push_back(hex_char($urandom_range(0, 15)));
            query_q.push_back(hex_char($urandom_range(0, 15)));
        end else if (pick == 14) begin
            // A stray character inside the escape is skipped.
            query_q.push_back(CH_PERCENT);
            case ($urandom_range(0, 2))
                0: query_q.push_back(CH_PERCENT);
                1: query_q.push_back(8'h61 + 8'($urandom_range(0, 5)));
                default: query_q.push_back(8'h47);
            endcase
            query_q.push_back(hex_char($urandom_range(0, 15)));
            query_q.push_back(hex_char($urandom_range(0, 15)));
        end else if (pick == 15) begin
            query_q.push_back(CH_PERCENT);
            query_q.push_back(hex_char($urandom_range(0, 15)));
        end else if (pick == 16) begin
            query_q.push_back(8'h00);
        end else begin
            query_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Query string of name=value segments joined by '&'; the last segment may have no '='.
    function automatic void build_query();
        int unsigned nseg;
        int unsigned nval;
        nseg = $urandom_range(1, 4);
        query_q.delete();
        for (int s = 0; s < nseg; s++) begin
            if (s != 0) query_q.push_back(CH_AMP);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: append_key(cur_len);
                4: append_key((cur_len > 0) ? cur_len - 1 : 0);
                5: begin
                    append_key(cur_len);
                    query_q.push_back(name_char());
                end
                6: begin
                end
                7: begin
                    // Key name that follows an earlier '=' in the same segment.
                    query_q.push_back(name_char());
                    query_q.push_back(CH_EQUAL);
                    append_key(cur_len);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) query_q.push_back(name_char());
                end
            endcase
            if (s == nseg - 1 && $urandom_range(0, 9) == 0) break;
            query_q.push_back(CH_EQUAL);
            nval = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
            repeat (nval) append_value_char();
        end
        if (query_q.size() == 0) query_q.push_back(name_char());
    endfunction

    // Random bytes with the separators and escape marks weighted up.
    function automatic void build_noise();
        query_q.delete();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 9))
                0: query_q.push_back(CH_EQUAL);
                1: query_q.push_back(CH_AMP);
                2: query_q.push_back(CH_PERCENT);
                3: query_q.push_back(CH_PLUS);
                default: query_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Stimulus.
    initial begin
        logic [63:0] key_value;
        int unsigned target;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_KEY_BYTES;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_byte   = '0;
        i_in_last   = 1'b0;
        sb = new();
        key_lens[NUM_SETTINGS-1] = $urandom_range(0, 15);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: key "ab". A name after an earlier '=', plus, zero and all-ones
        // bytes, an escaped plus, stray characters inside an escape, bytes after the value.
        set_key(4'd2, 64'hFFFF_FFFF_FFFF_6261);
        query_q.delete();
        push_text("c=ab=+");
        query_q.push_back(8'h00);
        query_q.push_back(8'hFF);
        push_text("%2B%4%G1&z");
        send_query();
        // Escape still open at the end of the string.
        query_q.delete();
        push_text("ab=%A");
        send_query();
        // Trailing segment with no '='.
        query_q.delete();
        push_text("ab");
        send_query();
        wait_drained();
        // Empty key matches an empty name.
        set_key(4'd0, 64'h0);
        query_q.delete();
        push_text("=v");
        send_query();

        // Random part, one key setting after another.
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            wait_drained();
            for (int i = 0; i < KEY_BYTES_MAX; i++) begin
                key_value[8*i +: 8] = (i < key_lens[p] && $urandom_range(0, 7) != 0) ?
                                      name_char() : 8'($urandom_range(0, 255));
            end
            set_key(4'(key_lens[p]), key_value);
            gaps_on = (p != 1);
            target = bytes_sent + RANDOM_BYTES / NUM_SETTINGS;
            if (p == 2) begin
                // Long value while the output side holds off: the block fills up.
                hold_request = 1'b1;
                query_q.delete();
                append_key(cur_len);
                query_q.push_back(CH_EQUAL);
                repeat (90) query_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
                send_query();
            end
            while (bytes_sent < target) begin
                if ($urandom_range(0, 9) < 8) begin
                    build_query();
                end else begin
                    build_noise();
                end
                send_query();
            end
        end
        gaps_on = 1'b1;

        wait_drained();
        if (sb.error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/qpud_pkg.sv
src/query_param_url_decoder_unit.sv
tb/qpud_tb_pkg.sv
tb/tb_top.sv
